// File: src/ffba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int MaxBlocks   = 64;
	localparam int HeaderBytes = 32;
	localparam int AddrBits    = 32;
	localparam int IdxBits     = $clog2(MaxBlocks);
	localparam int CntBits     = $clog2(MaxBlocks + 1);
	localparam int SizeBits    = 27;
	localparam int SumBits     = 33;
	localparam logic [SizeBits-1:0] SizeCap = SizeBits'(100000000);

	localparam logic [1:0] ReqMalloc  = 2'd0;
	localparam logic [1:0] ReqCalloc  = 2'd1;
	localparam logic [1:0] ReqFree    = 2'd2;
	localparam logic [1:0] ReqRealloc = 2'd3;

	localparam logic [1:0] StOk      = 2'd0;
	localparam logic [1:0] StBadSize = 2'd1;
	localparam logic [1:0] StNoMem   = 2'd2;
	localparam logic [1:0] StBadAddr = 2'd3;

	localparam logic [1:0] CfgBase  = 2'd0;
	localparam logic [1:0] CfgLimit = 2'd1;
	localparam logic [1:0] CfgMax   = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load;       // marks acceptance of a request; the datapath latches on start and not busy
		logic scan_clr;   // reset scan index
		logic scan_step;  // read next entry
		logic grab;       // claim the found free entry
		logic append;     // write new entry at the top
		logic release_k;  // mark the found entry free
		logic done;       // register the result
		logic [1:0] st;   // status of the result
		logic keep;       // realloc kept in place
		logic copy;       // realloc moved
		logic zero;       // calloc zero request
	} ffba_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] req;
		logic size_bad;
		logic addr_null;
		logic scan_end;   // index reached entry count
		logic hit_fit;    // entry under scan is free and big enough
		logic hit_addr;   // entry under scan matches the address
		logic k_free;
		logic k_big;
		logic can_append;
	} ffba_sts_t;

endpackage

// File: src/first_fit_block_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit heap block allocator with a 64-entry block table.
// ----------------------------------------------------------------------------
// A request (malloc, calloc, free, realloc) is taken when start is high and
// busy is low. Exactly one result follows, shown for one cycle with done high;
// the receiver cannot stall it. Statistics ports are live and show the values
// after the request whenever done is high.
// The configuration channel writes the heap base, the heap limit and the
// request size cap by index; it is always ready. The user writes it only while
// the block is idle; the block itself does not enforce this.
// A rejected size or a free of null is answered after the product and check
// states; busy drops as done rises.
// Address and first-fit scans walk the table one entry at a time through the
// registered read port of the table memory, waiting for each entry's read data.
// A malloc or calloc waits on one first-fit scan; a realloc that moves its
// block scans twice, first for the address and then for a fit.
// Reset clears the table count, statistics and heap top; table contents need
// no clearing pass since only entries below the count are read.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top import ffba_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          req_type,
	input  logic [31:0]         byte_size,
	input  logic [31:0]         elem_count,
	input  logic [31:0]         user_addr,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output logic                done,
	output logic [1:0]          status,
	output logic [31:0]         result_addr,
	output logic                copy_request,
	output logic [31:0]         copy_source,
	output logic [SizeBits-1:0] copy_length,
	output logic [SizeBits-1:0] zero_length,
	output logic [CntBits-1:0]  free_block_count,
	output logic [SumBits-1:0]  free_byte_total,
	output logic [CntBits-1:0]  block_total,
	output logic [SumBits-1:0]  byte_total
);

	ffba_cmd_t cmd;
	ffba_sts_t sts;

	assign cfg_ready = 1'b1;

	ffba_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	ffba_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start(start), .busy(busy), .req_type(req_type),
		.byte_size(byte_size), .elem_count(elem_count), .user_addr(user_addr),
		.cmd(cmd), .sts(sts), .done(done), .status(status),
		.result_addr(result_addr), .copy_request(copy_request),
		.copy_source(copy_source), .copy_length(copy_length),
		.zero_length(zero_length), .free_block_count(free_block_count),
		.free_byte_total(free_byte_total), .block_total(block_total),
		.byte_total(byte_total)
	);

endmodule

// File: src/ffba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer of the allocator: size check, address scan, first-fit scan.
// ----------------------------------------------------------------------------
module ffba_ctrl import ffba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  ffba_sts_t sts,
	output ffba_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_PROD, S_CHECK, S_AWAIT, S_ASCAN, S_ADEC,
		S_FSTART, S_FWAIT, S_FSCAN, S_DONE
	} state_t;

	state_t state_q;
	logic   realloc_q;   // fit scan belongs to a realloc move
	logic   fresh_q;     // entry read data is valid for the current index

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			realloc_q <= 1'b0;
			fresh_q   <= 1'b0;
			cmd       <= '0;
		end else begin
			cmd <= '0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd.load  <= 1'b1;
						realloc_q <= 1'b0;
						state_q   <= S_PROD;
					end
				end
				S_PROD: state_q <= S_CHECK;
				S_CHECK: begin
					cmd.scan_clr <= 1'b1;
					fresh_q      <= 1'b0;
					priority if (sts.req == ReqFree) begin
						if (sts.addr_null) begin
							cmd.done <= 1'b1;
							cmd.st   <= StOk;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_AWAIT;
						end
					end else if (sts.size_bad) begin
						cmd.done <= 1'b1;
						cmd.st   <= StBadSize;
						state_q  <= S_DONE;
					end else if (sts.req == ReqRealloc && !sts.addr_null) begin
						state_q <= S_AWAIT;
					end else begin
						state_q <= S_FWAIT;
					end
				end
				S_AWAIT: begin
					fresh_q <= 1'b1;
					state_q <= S_ASCAN;
				end
				S_ASCAN: begin
					// after each step, wait for the read data to line up before testing it
					if (!fresh_q) begin
						fresh_q <= 1'b1;
					end else if (sts.scan_end) begin
						cmd.done <= 1'b1;
						cmd.st   <= StBadAddr;
						state_q  <= S_DONE;
					end else if (sts.hit_addr) begin
						state_q <= S_ADEC;
					end else begin
						cmd.scan_step <= 1'b1;
						fresh_q       <= 1'b0;
					end
				end
				S_ADEC: begin
					priority if (sts.req == ReqFree) begin
						cmd.release_k <= !sts.k_free;
						cmd.done      <= 1'b1;
						cmd.st        <= StOk;
						state_q       <= S_DONE;
					end else if (sts.k_free) begin
						cmd.done <= 1'b1;
						cmd.st   <= StBadAddr;
						state_q  <= S_DONE;
					end else if (sts.k_big) begin
						cmd.done <= 1'b1;
						cmd.keep <= 1'b1;
						cmd.st   <= StOk;
						state_q  <= S_DONE;
					end else begin
						realloc_q <= 1'b1;
						state_q   <= S_FSTART;
					end
				end
				S_FSTART: begin
					cmd.scan_clr <= 1'b1;
					fresh_q      <= 1'b0;
					state_q      <= S_FWAIT;
				end
				S_FWAIT: begin
					fresh_q <= 1'b1;
					state_q <= S_FSCAN;
				end
				S_FSCAN: begin
					if (!fresh_q) begin
						fresh_q <= 1'b1;
					end else if (sts.scan_end) begin
						cmd.done <= 1'b1;
						if (sts.can_append) begin
							cmd.append    <= 1'b1;
							cmd.st        <= StOk;
							cmd.copy      <= realloc_q;
							cmd.release_k <= realloc_q;
							cmd.zero      <= (sts.req == ReqCalloc);
						end else begin
							cmd.st <= StNoMem;
						end
						state_q <= S_DONE;
					end else if (sts.hit_fit) begin
						cmd.done      <= 1'b1;
						cmd.grab      <= 1'b1;
						cmd.st        <= StOk;
						cmd.copy      <= realloc_q;
						cmd.release_k <= realloc_q;
						cmd.zero      <= (sts.req == ReqCalloc);
						state_q       <= S_DONE;
					end else begin
						cmd.scan_step <= 1'b1;
						fresh_q       <= 1'b0;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.grab && cmd.append)) else $error("grab and append together");
	a_done_ret: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done |=> state_q == S_IDLE) else $error("result not followed by idle");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> $past(state_q) == S_IDLE) else $error("load outside idle");

endmodule

// File: src/ffba_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_dp
// Datapath: block table memory, statistics, configuration, result register.
// ----------------------------------------------------------------------------
module ffba_dp import ffba_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                start,
	input  logic                busy,
	input  logic [1:0]          req_type,
	input  logic [31:0]         byte_size,
	input  logic [31:0]         elem_count,
	input  logic [31:0]         user_addr,
	input  ffba_cmd_t           cmd,
	output ffba_sts_t           sts,
	output logic                done,
	output logic [1:0]          status,
	output logic [31:0]         result_addr,
	output logic                copy_request,
	output logic [31:0]         copy_source,
	output logic [SizeBits-1:0] copy_length,
	output logic [SizeBits-1:0] zero_length,
	output logic [CntBits-1:0]  free_block_count,
	output logic [SumBits-1:0]  free_byte_total,
	output logic [CntBits-1:0]  block_total,
	output logic [SumBits-1:0]  byte_total
);

	localparam logic [AddrBits:0] AddrMax = {1'b0, {AddrBits{1'b1}}};

	logic [31:0]         limit_q;
	logic [SizeBits-1:0] maxsz_q;
	logic [CntBits-1:0]  count_q, nfree_q;
	logic [SumBits-1:0]  fsum_q, usum_q;
	logic [AddrBits-1:0] top_q;

	logic [1:0]          req_q;
	logic [31:0]         size_q, cnt_q, uaddr_q;
	logic [63:0]         prod_s1;
	logic [CntBits-1:0]  idx_q;
	logic [CntBits-1:0]  idx_nxt;
	logic [IdxBits-1:0]  rd_idx;
	logic [IdxBits-1:0]  k_q;
	logic [SizeBits-1:0] ksize_q;

	logic [AddrBits-1:0] mem_start [MaxBlocks];
	logic [SizeBits-1:0] mem_size  [MaxBlocks];
	logic                mem_free  [MaxBlocks];
	logic [AddrBits-1:0] rd_start_q;
	logic [SizeBits-1:0] rd_size_q;
	logic                rd_free_q;
	logic                rel_late_q;

	logic [SizeBits-1:0] lim;
	logic [63:0]         need64;
	logic [SizeBits-1:0] need;
	logic [AddrBits-1:0] user_rd;
	logic [AddrBits:0]   total, end_addr;

	assign lim    = (maxsz_q < SizeCap) ? maxsz_q : SizeCap;
	assign need64 = (req_q == ReqCalloc) ? prod_s1 : {32'd0, size_q};
	assign need   = need64[SizeBits-1:0];
	assign user_rd = rd_start_q + AddrBits'(HeaderBytes);
	assign total    = (AddrBits+1)'(HeaderBytes) + (AddrBits+1)'(need);
	assign end_addr = {1'b0, top_q} + total;

	// read ahead at the index the scan moves to, so read data tracks idx_q
	assign idx_nxt = cmd.scan_clr ? '0 : (cmd.scan_step ? idx_q + 1'b1 : idx_q);
	assign rd_idx  = idx_nxt[IdxBits-1:0];

	always_comb begin
		sts.req = req_q;
		if (req_q == ReqCalloc)
			sts.size_bad = (cnt_q == 32'd0) || (size_q == 32'd0) ||
				(prod_s1 > {37'd0, lim});
		else
			sts.size_bad = (size_q == 32'd0) || (size_q > {5'd0, lim});
		sts.addr_null  = (uaddr_q == 32'd0);
		sts.scan_end   = (idx_q >= count_q);
		sts.hit_fit    = rd_free_q && ({5'd0, rd_size_q} >= need64[31:0]);
		sts.hit_addr   = (user_rd == uaddr_q);
		sts.k_free     = rd_free_q;
		sts.k_big      = ({5'd0, rd_size_q} >= size_q);
		sts.can_append = (count_q < CntBits'(MaxBlocks)) && (end_addr <= AddrMax) &&
			(end_addr <= (AddrBits+1)'(limit_q));
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			mem_start[idx_q[IdxBits-1:0]] <= top_q;
			mem_size[idx_q[IdxBits-1:0]]  <= need;
			mem_free[idx_q[IdxBits-1:0]]  <= 1'b0;
		end else if (cmd.grab) begin
			mem_free[idx_q[IdxBits-1:0]] <= 1'b0;
		end
		if ((cmd.release_k && !cmd.append && !cmd.grab) || rel_late_q)
			mem_free[k_q] <= 1'b1;
		rd_start_q <= mem_start[rd_idx];
		rd_size_q  <= mem_size[rd_idx];
		rd_free_q  <= mem_free[rd_idx];
	end

	// realloc move releases the old entry in the cycle after the grab or append
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rel_late_q <= 1'b0;
		else         rel_late_q <= cmd.release_k && (cmd.append || cmd.grab);
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			size_q  <= byte_size;
			cnt_q   <= elem_count;
			uaddr_q <= user_addr;
		end
		prod_s1 <= 64'(cnt_q) * 64'(size_q);
		if (sts.hit_addr && !sts.scan_end && !cmd.scan_step) begin
			k_q     <= idx_q[IdxBits-1:0];
			ksize_q <= rd_size_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '1;
			maxsz_q <= SizeCap;
			top_q   <= '0;
			count_q <= '0;
			nfree_q <= '0;
			fsum_q  <= '0;
			usum_q  <= '0;
			idx_q   <= '0;
			req_q   <= ReqMalloc;
			done    <= 1'b0;
		end else begin
			done <= cmd.done;
			if (start && !busy) req_q <= req_type;
			if (cfg_valid) begin
				unique case (cfg_index)
					CfgBase: begin
						if (count_q == '0) top_q <= AddrBits'(cfg_data);
					end
					CfgLimit: limit_q <= cfg_data;
					CfgMax:   maxsz_q <= cfg_data[SizeBits-1:0];
					default: ;
				endcase
			end
			idx_q <= idx_nxt;
			if (cmd.append) begin
				count_q <= count_q + 1'b1;
				usum_q  <= usum_q + SumBits'(need);
				top_q   <= end_addr[AddrBits-1:0];
			end
			begin : stats
				logic [CntBits-1:0] nf;
				logic [SumBits-1:0] fs;
				nf = nfree_q;
				fs = fsum_q;
				if (cmd.grab) begin
					nf = nf - 1'b1;
					fs = fs - SumBits'(rd_size_q);
				end
				if (cmd.release_k) begin
					nf = nf + 1'b1;
					fs = fs + SumBits'(cmd.copy ? ksize_q : rd_size_q);
				end
				nfree_q <= nf;
				fsum_q  <= fs;
			end
		end
	end

	// result register; statistics are read after the update lands
	always_ff @(posedge clk) begin
		if (cmd.done) begin
			status       <= cmd.st;
			result_addr  <= '0;
			copy_request <= cmd.copy;
			copy_source  <= cmd.copy ? uaddr_q : 32'd0;
			copy_length  <= cmd.copy ? ksize_q : '0;
			zero_length  <= cmd.zero ? need : '0;
			if (cmd.keep)
				result_addr <= uaddr_q;
			else if (cmd.grab)
				result_addr <= user_rd;
			else if (cmd.append)
				result_addr <= top_q + AddrBits'(HeaderBytes);
		end
	end

	assign free_block_count = nfree_q;
	assign free_byte_total  = fsum_q;
	assign block_total      = count_q;
	assign byte_total       = usum_q;

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntBits'(MaxBlocks)) else $error("table overflow");
	a_free_le: assert property (@(posedge clk) disable iff (!arst_n)
		nfree_q <= count_q) else $error("more free blocks than blocks");
	a_app_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> count_q < CntBits'(MaxBlocks)) else $error("append when full");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit block allocator.
// ----------------------------------------------------------------------------
// Requests are sent through the start/busy handshake with random gaps. A
// scoreboard models the block table, heap top and statistics. It predicts the
// result of each accepted request and checks every done strobe against the
// oldest prediction. Configuration is changed only while the block is idle.
// The random part mostly frees and reallocates live blocks and mixes in
// null, stale and random addresses.
// ----------------------------------------------------------------------------
module testbench;
	import ffba_pkg::*;

	typedef struct {
		logic [1:0]          status;
		logic [31:0]         result_addr;
		logic                copy_request;
		logic [31:0]         copy_source;
		logic [SizeBits-1:0] copy_length;
		logic [SizeBits-1:0] zero_length;
		logic [CntBits-1:0]  free_block_count;
		logic [SumBits-1:0]  free_byte_total;
		logic [CntBits-1:0]  block_total;
		logic [SumBits-1:0]  byte_total;
	} alloc_result_t;

	class alloc_scoreboard;
		logic [31:0]         blk_start [MaxBlocks];
		logic [SizeBits-1:0] blk_size  [MaxBlocks];
		bit                  blk_free  [MaxBlocks];
		int                  blk_count;
		longint unsigned     top, base_reg, limit_reg, max_reg;
		int                  free_cnt;
		longint unsigned     free_sum, used_sum;
		alloc_result_t       pending [$];
		int                  errors, checked;
		int                  st_seen [4];

		function new();
			base_reg  = 0;
			limit_reg = 32'hFFFF_FFFF;
			max_reg   = 100000000;
			top       = 0;
			blk_count = 0;
			free_cnt  = 0;
			free_sum  = 0;
			used_sum  = 0;
			errors    = 0;
			checked   = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				CfgBase: begin
					base_reg = val;
					if (blk_count == 0) top = val;
				end
				CfgLimit: limit_reg = val;
				CfgMax:   max_reg = val[SizeBits-1:0];
				default: ;
			endcase
		endfunction

		function longint unsigned size_cap();
			return (max_reg < 100000000) ? max_reg : 100000000;
		endfunction

		function logic [31:0] user_addr_of(int i);
			return blk_start[i] + 32'(HeaderBytes);
		endfunction

		function int lookup(logic [31:0] addr);
			for (int i = 0; i < blk_count; i++)
				if (user_addr_of(i) == addr) return i;
			return -1;
		endfunction

		// first-fit reuse, else append at the heap top
		function logic [1:0] grant(longint unsigned sz, output logic [31:0] addr);
			longint unsigned total;
			addr = 0;
			for (int i = 0; i < blk_count; i++) begin
				if (blk_free[i] && blk_size[i] >= sz) begin
					blk_free[i] = 0;
					free_cnt--;
					free_sum -= blk_size[i];
					addr = user_addr_of(i);
					return StOk;
				end
			end
			if (blk_count >= MaxBlocks) return StNoMem;
			total = HeaderBytes + sz;
			if (top > 64'hFFFF_FFFF - total) return StNoMem;
			if (top + total > limit_reg) return StNoMem;
			blk_start[blk_count] = top;
			blk_size[blk_count]  = sz;
			blk_free[blk_count]  = 0;
			addr = user_addr_of(blk_count);
			blk_count++;
			used_sum += sz;
			top += total;
			return StOk;
		endfunction

		function void note_request(logic [1:0] kind, logic [31:0] sz, logic [31:0] cnt,
				logic [31:0] uaddr);
			alloc_result_t r;
			longint unsigned lim, prod;
			int k;
			lim = size_cap();
			r = '{default: '0};
			case (kind)
				ReqMalloc: begin
					if (sz == 0 || sz > lim) r.status = StBadSize;
					else r.status = grant(sz, r.result_addr);
				end
				ReqCalloc: begin
					prod = longint'(cnt) * longint'(sz);
					if (cnt == 0 || sz == 0 || prod > lim) r.status = StBadSize;
					else begin
						r.status = grant(prod, r.result_addr);
						if (r.status == StOk) r.zero_length = prod;
					end
				end
				ReqFree: begin
					if (uaddr != 0) begin
						k = lookup(uaddr);
						if (k < 0) r.status = StBadAddr;
						else if (!blk_free[k]) begin
							blk_free[k] = 1;
							free_cnt++;
							free_sum += blk_size[k];
						end
					end
				end
				default: begin
					if (sz == 0 || sz > lim) r.status = StBadSize;
					else if (uaddr == 0) r.status = grant(sz, r.result_addr);
					else begin
						k = lookup(uaddr);
						if (k < 0 || blk_free[k]) r.status = StBadAddr;
						else if (blk_size[k] >= sz) r.result_addr = uaddr;
						else begin
							r.status = grant(sz, r.result_addr);
							if (r.status == StOk) begin
								r.copy_request = 1;
								r.copy_source  = uaddr;
								r.copy_length  = blk_size[k];
								blk_free[k] = 1;
								free_cnt++;
								free_sum += blk_size[k];
							end else r.result_addr = 0;
						end
					end
				end
			endcase
			r.free_block_count = free_cnt;
			r.free_byte_total  = free_sum;
			r.block_total      = blk_count;
			r.byte_total       = used_sum;
			st_seen[r.status]++;
			pending.push_back(r);
		endfunction

		function void report(string msg);
			errors++;
			$display("MISMATCH @%0t: %s", $time, msg);
		endfunction

		function void check_result(alloc_result_t got);
			alloc_result_t exp;
			if (pending.size() == 0) begin
				report("result with no request outstanding");
				return;
			end
			exp = pending.pop_front();
			checked++;
			if (got.status !== exp.status)
				report($sformatf("status %0d exp %0d", got.status, exp.status));
			if (got.result_addr !== exp.result_addr)
				report($sformatf("result_addr %h exp %h", got.result_addr, exp.result_addr));
			if (got.copy_request !== exp.copy_request)
				report($sformatf("copy_request %b exp %b", got.copy_request, exp.copy_request));
			if (got.copy_source !== exp.copy_source)
				report($sformatf("copy_source %h exp %h", got.copy_source, exp.copy_source));
			if (got.copy_length !== exp.copy_length)
				report($sformatf("copy_length %0d exp %0d", got.copy_length, exp.copy_length));
			if (got.zero_length !== exp.zero_length)
				report($sformatf("zero_length %0d exp %0d", got.zero_length, exp.zero_length));
			if (got.free_block_count !== exp.free_block_count)
				report($sformatf("free_block_count %0d exp %0d", got.free_block_count,
					exp.free_block_count));
			if (got.free_byte_total !== exp.free_byte_total)
				report($sformatf("free_byte_total %0d exp %0d", got.free_byte_total,
					exp.free_byte_total));
			if (got.block_total !== exp.block_total)
				report($sformatf("block_total %0d exp %0d", got.block_total, exp.block_total));
			if (got.byte_total !== exp.byte_total)
				report($sformatf("byte_total %0d exp %0d", got.byte_total, exp.byte_total));
		endfunction
	endclass

	logic                clk, arst_n;
	logic                start, busy;
	logic [1:0]          req_type;
	logic [31:0]         byte_size, elem_count, user_addr;
	logic                cfg_valid, cfg_ready;
	logic [1:0]          cfg_index;
	logic [31:0]         cfg_data;
	logic                done;
	logic [1:0]          status;
	logic [31:0]         result_addr;
	logic                copy_request;
	logic [31:0]         copy_source;
	logic [SizeBits-1:0] copy_length, zero_length;
	logic [CntBits-1:0]  free_block_count, block_total;
	logic [SumBits-1:0]  free_byte_total, byte_total;

	alloc_scoreboard sb;
	int unsigned     cycles;
	int              sent;

	first_fit_block_allocator_top dut (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("timeout waiting for results");
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result('{status, result_addr, copy_request, copy_source, copy_length,
				zero_length, free_block_count, free_byte_total, block_total, byte_total});
	end

	task automatic idle_gap();
		int n;
		int roll;
		roll = $urandom_range(0, 99);
		n = (roll < 55) ? 0 : (roll < 92) ? $urandom_range(1, 3) : $urandom_range(10, 60);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_request(logic [1:0] kind, logic [31:0] sz, logic [31:0] cnt,
			logic [31:0] uaddr);
		start      <= 1'b1;
		req_type   <= kind;
		byte_size  <= sz;
		elem_count <= cnt;
		user_addr  <= uaddr;
		do @(posedge clk); while (busy);
		sb.note_request(kind, sz, cnt, uaddr);
		sent++;
		idle_gap();
	endtask

	// hold until every result is in and the block is quiet
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_size();
		int roll;
		longint unsigned lim;
		lim = sb.size_cap();
		roll = $urandom_range(0, 99);
		if (roll < 65) return $urandom_range(1, 256);
		if (roll < 80) return $urandom_range(1, 1 << 20);
		if (roll < 85) return 0;
		if (roll < 90) return $urandom;
		if (roll < 95) return lim;
		return lim + 1;
	endfunction

	function automatic logic [31:0] pick_addr();
		int roll;
		roll = $urandom_range(0, 99);
		if (sb.blk_count > 0 && roll < 80)
			return sb.user_addr_of($urandom_range(0, sb.blk_count - 1));
		if (roll < 90) return 0;
		if (roll < 95 && sb.blk_count > 0)
			return sb.user_addr_of($urandom_range(0, sb.blk_count - 1)) + 1;
		return $urandom;
	endfunction

	task automatic random_phase(int n);
		int roll;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 28) send_request(ReqMalloc, pick_size(), $urandom, $urandom);
			else if (roll < 42) begin
				if ($urandom_range(0, 9) == 0)
					send_request(ReqCalloc, $urandom, $urandom, $urandom);
				else
					send_request(ReqCalloc, $urandom_range(0, 64), $urandom_range(0, 40),
						$urandom);
			end
			else if (roll < 72) send_request(ReqFree, $urandom, $urandom, pick_addr());
			else send_request(ReqRealloc, pick_size(), $urandom, pick_addr());
		end
	endtask

	initial begin
		logic [31:0] a0, a1;
		sb         = new();
		cycles     = 0;
		sent       = 0;
		arst_n     = 1'b0;
		start      = 1'b0;
		req_type   = ReqMalloc;
		byte_size  = '0;
		elem_count = '0;
		user_addr  = '0;
		cfg_valid  = 1'b0;
		cfg_index  = CfgBase;
		cfg_data   = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// top near the end of the address space: append must overflow
		write_cfg(CfgBase, 32'hFFFF_FFF0);
		send_request(ReqMalloc, 1, 0, 0);
		drain();
		write_cfg(CfgLimit, 0);
		write_cfg(CfgBase, 32'h0000_0100);
		send_request(ReqMalloc, 8, 0, 0);
		drain();
		write_cfg(CfgLimit, 32'hFFFF_FFFF);
		write_cfg(CfgMax, 32'h07FF_FFFF);

		send_request(ReqMalloc, 0, 0, 0);
		send_request(ReqMalloc, 100000001, 0, 0);
		send_request(ReqMalloc, 100000000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(ReqMalloc, 16, 0, 0);
		send_request(ReqCalloc, 5, 0, 0);
		send_request(ReqCalloc, 0, 7, 0);
		send_request(ReqCalloc, 5, 3, 0);
		send_request(ReqCalloc, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		a0 = 32'h100 + 32'(HeaderBytes);
		a1 = sb.user_addr_of(1);
		send_request(ReqFree, 0, 0, 0);
		send_request(ReqFree, 0, 0, a0);
		send_request(ReqFree, 0, 0, a0);
		send_request(ReqFree, 0, 0, 32'h1234_5677);
		send_request(ReqRealloc, 0, 0, a1);
		send_request(ReqRealloc, 24, 0, 0);
		send_request(ReqRealloc, 8, 0, a0);
		send_request(ReqRealloc, 4, 0, a1);
		send_request(ReqRealloc, 4000, 0, a1);
		send_request(ReqMalloc, 12, 0, 0);
		send_request(ReqFree, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain();

		random_phase(450);
		drain();
		write_cfg(CfgMax, 1);
		write_cfg(CfgBase, 32'hDEAD_0000);
		random_phase(250);
		drain();
		write_cfg(CfgMax, 4096);
		write_cfg(CfgLimit, 32'(sb.top + 20000));
		random_phase(450);
		drain();
		write_cfg(CfgMax, 100000000);
		write_cfg(CfgLimit, 32'(sb.top + 64));
		random_phase(250);
		drain();
		write_cfg(CfgLimit, 32'hFFFF_FFFF);
		random_phase(400);
		drain();
		repeat (20) @(posedge clk);

		$display("covered %0d requests, %0d results checked, %0d table entries in use",
			sent, sb.checked, sb.blk_count);
		$display("status mix: ok %0d, bad size %0d, no memory %0d, bad address %0d",
			sb.st_seen[0], sb.st_seen[1], sb.st_seen[2], sb.st_seen[3]);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
